// File: sv/hpe_pkg.sv
// Shared types, widths and a helper function of the Hermite polynomial evaluator.
package hpe_pkg;

  localparam int unsigned DW = 64;  // result width
  localparam int unsigned XW = 16;  // argument width
  localparam int unsigned MW = 6;   // recurrence count width, holds degrees up to 63
  localparam int unsigned FW = 12;  // derivative factor width, holds 63*62
  localparam int unsigned WW = 84;  // exact width of one recurrence sum

  typedef enum logic [1:0] {
    FUNC_VAL = 2'd0,
    FUNC_D1  = 2'd1,
    FUNC_D2  = 2'd2,
    FUNC_NA  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_MUL  = 2'd1,
    MODE_ZERO = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]          func;
    logic signed [XW-1:0] x;
    logic [4:0]          order;
  } in_req_t;

  typedef struct packed {
    logic signed [DW-1:0] result;
    logic                 saturated;
  } out_rsp_t;

  // State carried from one cell to the next.
  typedef struct packed {
    logic                 valid;
    logic signed [DW-1:0] prev;
    logic signed [DW-1:0] cur;
    logic signed [XW-1:0] x;
    logic [MW-1:0]        steps;
    logic [FW-1:0]        factor;
    mode_e                mode;
    logic                 sat;
  } cell_t;

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 clip;
  } clamp_t;

  // Clip a wide signed value to the result range.
  function automatic clamp_t clamp_w(input logic signed [WW-1:0] v);
    clamp_t r;
    r.value = v[DW-1:0];
    r.clip  = 1'b0;
    if ((v[WW-1:DW-1] != '0) && (v[WW-1:DW-1] != '1)) begin
      r.clip  = 1'b1;
      r.value = v[WW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: sv/hpe_cell.sv
// One recurrence cell: applies step K of He_{k+1} = x*He_k - k*He_{k-1} when the item needs it.
module hpe_cell import hpe_pkg::*; #(
  parameter int unsigned K = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  cell_t cell_i,
  output cell_t cell_o
);

  localparam logic signed [7:0] KS = 8'(K);

  logic signed [WW-1:0] prod_a;
  logic signed [WW-1:0] prod_b;
  logic signed [WW-1:0] sum;
  clamp_t               nxt;
  logic                 active;
  cell_t                cell_d;
  cell_t                cell_q;

  assign prod_a = cell_i.cur * cell_i.x;
  assign prod_b = cell_i.prev * KS;
  assign sum    = prod_a - (prod_b <<< 12) + WW'(2048);
  assign nxt    = clamp_w(sum >>> 12);
  assign active = (MW'(K) < cell_i.steps);

  always_comb begin
    cell_d = cell_i;
    if (active) begin
      cell_d.prev = cell_i.cur;
      cell_d.cur  = nxt.value;
      cell_d.sat  = cell_i.sat | nxt.clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (adv_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: sv/hermite_poly_eval.sv
// Top level of the probabilists' Hermite polynomial evaluator: cell chain and output register.
//
//   Channel | Handshake                | Payload
//   --------+--------------------------+--------------------------------------
//   in      | in_valid_i / in_ready_o  | in_req_i  (func, x, order)
//   out     | out_valid_o / out_ready_i| out_rsp_o (result, saturated)
//
// An accepted request walks down a chain of MAX_ORDER cells, one cell per cycle while
// the output does not stall, and cell k applies recurrence step k only when the
// request needs that step. The chain holds one request at a time, so a new request is
// taken only once the previous one has entered the output register; the request rate
// is thus set by the length of the cell chain.
// A stalled output freezes the whole chain while a finished request waits at its end;
// reset clears the cells and the valid bits, while the output data register is not
// reset.
module hermite_poly_eval import hpe_pkg::*; #(
  parameter int unsigned MAX_ORDER = 31,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_rsp_o
);

  cell_t                chain [MAX_ORDER+1];
  logic [MAX_ORDER-1:0] valid_vec;
  logic                 busy_q, busy_d;
  logic                 out_valid_q, out_valid_d;
  out_rsp_t             out_q, out_d;
  logic                 accept;
  logic                 adv;
  logic                 load;
  logic [MW-1:0]        n;
  cell_t                entry;
  cell_t                last;
  logic signed [WW-1:0] fprod;
  clamp_t               fclamp;

  assign accept = in_valid_i & in_ready_o;
  assign in_ready_o = ~busy_q;

  // Degree above the supported maximum is reduced to it.
  assign n = (MW'(in_req_i.order) > MW'(MAX_ORDER)) ? MW'(MAX_ORDER) : MW'(in_req_i.order);

  // Build the entry state: He_{-1} = 0, He_0 = 1, and the number of steps needed.
  always_comb begin
    entry.valid  = accept;
    entry.prev   = '0;
    entry.cur    = DW'(1) << FRAC_BITS;
    entry.x      = in_req_i.x;
    entry.sat    = 1'b0;
    entry.steps  = '0;
    entry.factor = '0;
    entry.mode   = MODE_ZERO;
    case (func_e'(in_req_i.func))
      FUNC_VAL: begin
        entry.steps = n;
        entry.mode  = MODE_PASS;
      end
      FUNC_D1: begin
        if (n >= MW'(1)) begin
          entry.steps  = n - MW'(1);
          entry.factor = FW'(n);
          entry.mode   = MODE_MUL;
        end
      end
      FUNC_D2: begin
        if (n >= MW'(2)) begin
          entry.steps  = n - MW'(2);
          entry.factor = FW'(n) * FW'(n - MW'(1));
          entry.mode   = MODE_MUL;
        end
      end
      default: begin
        entry.mode = MODE_ZERO;
      end
    endcase
  end

  assign chain[0] = entry;

  for (genvar g = 0; g < MAX_ORDER; g++) begin : g_cell
    hpe_cell #(.K(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
    assign valid_vec[g] = chain[g+1].valid;
  end

  assign last = chain[MAX_ORDER];

  // The chain freezes only when a finished request cannot enter the output register.
  assign adv  = ~(last.valid & out_valid_q & ~out_ready_i);
  assign load = last.valid & adv;

  // Derivative scaling by n or n*(n-1), an exact product clipped to the result range.
  assign fprod  = last.cur * $signed({1'b0, last.factor});
  assign fclamp = clamp_w(fprod);

  always_comb begin
    out_d = out_q;
    if (load) begin
      case (last.mode)
        MODE_PASS: begin
          out_d.result    = last.cur;
          out_d.saturated = last.sat;
        end
        MODE_MUL: begin
          out_d.result    = fclamp.value;
          out_d.saturated = last.sat | fclamp.clip;
        end
        default: begin
          out_d.result    = '0;
          out_d.saturated = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (load) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTHESIS
  // An accepted request marks the block busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("request accepted but block not busy");

  // No request is in the chain while the block is idle.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (valid_vec == '0))
    else $error("chain holds a request while idle");

  // The chain never holds more than one request.
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(valid_vec))
    else $error("more than one request in the chain");
`endif

endmodule
